// ===== src/ufa_pkg.sv =====
// ----------------------------------------------------------------------------
// ufa_pkg: shared constants and types of the union-find accumulator
// widths of the stream fields, the node store size, the event passed from
// the find sequencer to the accumulator, and node count clipping
// ----------------------------------------------------------------------------
package ufa_pkg;

   // node store size and derived index widths
   localparam int MAX_NODES = 1024;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int COUNT_W   = NODE_W + 1;

   // stream field widths
   localparam int FIELD_NODE_W = 10;
   localparam int CSR_W        = 11;
   localparam int WEIGHT_W     = 41;
   localparam int COST_W       = 63;
   localparam int SETS_W       = 11;
   localparam int REQ_DATA_W   = 64;
   localparam int RSP_DATA_W   = 80;

   localparam logic [COST_W-1:0] COST_MAX         = '1;
   localparam logic [CSR_W-1:0]  NODE_COUNT_RESET = CSR_W'(1024);

   // finished word handed from the sequencer to the accumulator
   typedef struct packed {
      logic                done;
      logic                restart;
      logic                joined;
      logic [WEIGHT_W-1:0] weight;
   } ev_type;

   // zero counts as one, anything above the store size as the store size
   function automatic logic [COUNT_W-1:0] eff_count(input logic [CSR_W-1:0] value);
      logic [COUNT_W-1:0] c;
      if (value == '0) begin
         c = COUNT_W'(1);
      end else if (32'(value) > MAX_NODES) begin
         c = COUNT_W'(MAX_NODES);
      end else begin
         c = COUNT_W'(value);
      end
      return c;
   endfunction

endpackage

// ===== src/ufa_ram.sv =====
// ----------------------------------------------------------------------------
// ufa_ram: generic simple dual-port ram
// one write port and one read port, read data registered, old data returned
// on a read of the address being written
// ----------------------------------------------------------------------------
module ufa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ufa_find.sv =====
// ----------------------------------------------------------------------------
// ufa_find: parent store and root-finding sequencer
// walks the parent chains of both endpoints one node per cycle, rewrites each
// visited node to point at its root, links the two roots, and sweeps the
// store back to self-parents after reset and after a restart
// ----------------------------------------------------------------------------
module ufa_find (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_func,
   input  logic [ufa_pkg::FIELD_NODE_W-1:0]     req_node_a,
   input  logic [ufa_pkg::FIELD_NODE_W-1:0]     req_node_b,
   input  logic [ufa_pkg::WEIGHT_W-1:0]         req_weight,
   input  logic                                 csr_restart,
   input  logic [ufa_pkg::COUNT_W-1:0]          count,
   input  logic                                 out_free,
   output ufa_pkg::ev_type                      ev
);
   import ufa_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CLEAR = 5'b00010,
      S_WALK  = 5'b00100,
      S_COMP  = 5'b01000,
      S_LINK  = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [NODE_W-1:0]   clr_ff, clr_in;
   logic                phase_ff, phase_in;
   logic [NODE_W-1:0]   cur_ff, cur_in;
   logic [NODE_W-1:0]   a_ff, a_in;
   logic [NODE_W-1:0]   b_ff, b_in;
   logic [NODE_W-1:0]   root_a_ff, root_a_in;
   logic [NODE_W-1:0]   root_b_ff, root_b_in;
   logic [WEIGHT_W-1:0] w_ff, w_in;

   logic                wr_en;
   logic [NODE_W-1:0]   wr_addr;
   logic [NODE_W-1:0]   wr_data;
   logic [NODE_W-1:0]   rd_addr;
   logic [NODE_W-1:0]   rd_data;

   logic                accept;
   logic                in_range;
   logic [COUNT_W-1:0]  last_idx;
   logic [NODE_W-1:0]   start_node;
   logic [NODE_W-1:0]   root_cur;

   ufa_ram #(
      .WIDTH (NODE_W),
      .DEPTH (MAX_NODES)
   ) u_parent (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready  = (state_ff == S_IDLE) && out_free;
   assign accept     = req_valid && req_ready;
   assign in_range   = (COUNT_W'(req_node_a) < count) && (COUNT_W'(req_node_b) < count);
   assign last_idx   = count - COUNT_W'(1);
   assign start_node = phase_ff ? b_ff : a_ff;
   assign root_cur   = phase_ff ? root_b_ff : root_a_ff;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      phase_in  = phase_ff;
      cur_in    = cur_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      root_a_in = root_a_ff;
      root_b_in = root_b_ff;
      w_in      = w_ff;
      wr_en     = 1'b0;
      wr_addr   = cur_ff;
      wr_data   = root_cur;
      rd_addr   = cur_ff;
      ev        = '0;
      ev.weight = w_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_func) begin
                  ev.done    = 1'b1;
                  ev.restart = 1'b1;
                  clr_in     = '0;
                  state_in   = S_CLEAR;
               end else if (!in_range) begin
                  ev.done = 1'b1;
               end else begin
                  a_in     = NODE_W'(req_node_a);
                  b_in     = NODE_W'(req_node_b);
                  w_in     = req_weight;
                  rd_addr  = NODE_W'(req_node_a);
                  cur_in   = NODE_W'(req_node_a);
                  phase_in = 1'b0;
                  state_in = S_WALK;
               end
            end
         end
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = clr_ff;
            if ({1'b0, clr_ff} == last_idx) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + NODE_W'(1);
            end
         end
         S_WALK: begin
            if (rd_data == cur_ff) begin
               // root found
               if (phase_ff) begin
                  root_b_in = cur_ff;
               end else begin
                  root_a_in = cur_ff;
               end
               if (start_node == cur_ff) begin
                  // start node is its own root, nothing to compress
                  if (phase_ff) begin
                     state_in = S_LINK;
                  end else begin
                     phase_in = 1'b1;
                     rd_addr  = b_ff;
                     cur_in   = b_ff;
                  end
               end else begin
                  rd_addr  = start_node;
                  cur_in   = start_node;
                  state_in = S_COMP;
               end
            end else begin
               rd_addr = rd_data;
               cur_in  = rd_data;
            end
         end
         S_COMP: begin
            // point the visited node straight at its root
            wr_en = 1'b1;
            if (rd_data == root_cur) begin
               if (phase_ff) begin
                  state_in = S_LINK;
               end else begin
                  phase_in = 1'b1;
                  rd_addr  = b_ff;
                  cur_in   = b_ff;
                  state_in = S_WALK;
               end
            end else begin
               rd_addr = rd_data;
               cur_in  = rd_data;
            end
         end
         S_LINK: begin
            if (out_free) begin
               ev.done   = 1'b1;
               ev.joined = (root_a_ff != root_b_ff);
               wr_en     = (root_a_ff != root_b_ff);
               wr_addr   = root_b_ff;
               wr_data   = root_a_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a node count write restarts the sweep
      if (csr_restart) begin
         clr_in   = '0;
         state_in = S_CLEAR;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         phase_ff <= phase_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      root_a_ff <= root_a_in;
      root_b_ff <= root_b_in;
      w_ff      <= w_in;
   end

endmodule

// ===== src/ufa_acc.sv =====
// ----------------------------------------------------------------------------
// ufa_acc: cost and set count accumulator with result register
// adds the weight of each joining edge with saturation, counts the sets
// left, and holds the result word until the receiver takes it
// ----------------------------------------------------------------------------
module ufa_acc (
   input  logic                         clock,
   input  logic                         reset,
   input  ufa_pkg::ev_type              ev,
   input  logic                         csr_restart,
   input  logic [ufa_pkg::COUNT_W-1:0]  count_wr,
   input  logic [ufa_pkg::COUNT_W-1:0]  count,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic                         rsp_joined,
   output logic [ufa_pkg::COST_W-1:0]   rsp_total,
   output logic [ufa_pkg::SETS_W-1:0]   rsp_sets,
   output logic                         out_free
);
   import ufa_pkg::*;

   logic [COST_W-1:0]  cost_ff, cost_in;
   logic [COUNT_W-1:0] sets_ff, sets_in;
   logic               valid_ff, valid_in;
   logic               joined_ff;
   logic [COST_W-1:0]  total_ff;
   logic [SETS_W-1:0]  sets_out_ff;
   logic [COST_W:0]    sum;
   logic [COST_W-1:0]  link_cost;

   // saturating add
   assign sum       = {1'b0, cost_ff} + (COST_W + 1)'(ev.weight);
   assign link_cost = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];

   // running state
   always_comb begin
      cost_in = cost_ff;
      sets_in = sets_ff;
      if (csr_restart) begin
         cost_in = '0;
         sets_in = count_wr;
      end else if (ev.done) begin
         if (ev.restart) begin
            cost_in = '0;
            sets_in = count;
         end else if (ev.joined) begin
            cost_in = link_cost;
            if (sets_ff > COUNT_W'(1)) begin
               sets_in = sets_ff - COUNT_W'(1);
            end
         end
      end
   end

   // result register handshake
   always_comb begin
      valid_in = valid_ff;
      if (ev.done) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cost_ff  <= '0;
         sets_ff  <= eff_count(NODE_COUNT_RESET);
         valid_ff <= 1'b0;
      end else begin
         cost_ff  <= cost_in;
         sets_ff  <= sets_in;
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (ev.done) begin
         joined_ff   <= ev.joined;
         total_ff    <= cost_in;
         sets_out_ff <= SETS_W'(sets_in);
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_joined = joined_ff;
   assign rsp_total  = total_ff;
   assign rsp_sets   = sets_out_ff;
   assign out_free   = !valid_ff || rsp_ready;

endmodule

// ===== src/kruskal_union_find_accumulator.sv =====
// ----------------------------------------------------------------------------
// kruskal_union_find_accumulator: spanning tree cost over a union-find store
// The sender must give edges on the req_ channel in nondecreasing weight
// order, which the block does not enforce; a word with req_tuser set is a
// restart. Every accepted word gives one rsp_ word: the joined flag, the
// saturating total cost and the number of sets left. An edge walks the
// parent chain of each endpoint one node per cycle through the
// registered-read parent ram, then walks it again to compress it, then
// links the roots; the next word is taken only after its result is given.
// Edges with an endpoint outside the node count and restart words answer
// in the cycle after they are taken.
// req_tready is low while an edge is in work and while a result waits on a
// stalled receiver.
// After reset, after a restart word and after a csr_we write of the node
// count, the store is swept back to self-parents one node per cycle, over
// as many nodes as the effective node count (1024 after reset); no word is
// taken meanwhile. A node count of zero counts as one.
// ----------------------------------------------------------------------------
module kruskal_union_find_accumulator (
   input  logic                              clock,
   input  logic                              reset,
   // node_a [9:0], node_b [19:10], weight [60:20]
   input  logic [ufa_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func [0]
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // joined [0], total_cost [63:1], sets_left [74:64]
   output logic [ufa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [ufa_pkg::CSR_W-1:0]         csr_wdata
);
   import ufa_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] count_wr;
   ev_type             ev;
   logic               out_free;
   logic               rsp_joined;
   logic [COST_W-1:0]  rsp_total;
   logic [SETS_W-1:0]  rsp_sets;

   // effective node count register
   assign count_wr = eff_count(csr_wdata);
   assign count_in = csr_we ? count_wr : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= eff_count(NODE_COUNT_RESET);
      end else begin
         count_ff <= count_in;
      end
   end

   ufa_find u_find (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_func    (req_tuser),
      .req_node_a  (req_tdata[9:0]),
      .req_node_b  (req_tdata[19:10]),
      .req_weight  (req_tdata[60:20]),
      .csr_restart (csr_we),
      .count       (count_ff),
      .out_free    (out_free),
      .ev          (ev)
   );

   ufa_acc u_acc (
      .clock       (clock),
      .reset       (reset),
      .ev          (ev),
      .csr_restart (csr_we),
      .count_wr    (count_wr),
      .count       (count_ff),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_joined  (rsp_joined),
      .rsp_total   (rsp_total),
      .rsp_sets    (rsp_sets),
      .out_free    (out_free)
   );

   // result word packing
   assign rsp_tdata = {5'b0, rsp_sets, rsp_total, rsp_joined};

   // no word is taken while a result is stuck at a stalled receiver
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("word accepted while result register blocked");

   // at least one set always remains
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_sets != '0))
      else $error("sets_left reported as zero");

   // a restart word answers next cycle with a cleared total
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=>
         (rsp_tvalid && !rsp_joined && (rsp_total == '0)))
      else $error("restart result not cleared");

endmodule

// ===== tb/tb_kruskal_union_find_accumulator.sv =====
// ----------------------------------------------------------------------------
// tb_kruskal_union_find_accumulator: self-checking bench for the union-find
// spanning tree accumulator
// A queue of edge and restart words feeds a clocked driver. A clocked monitor
// keeps its own disjoint-set store with path compression. It predicts joined,
// total cost and sets left for every accepted word and checks each result
// word in order. Phases change the node count and the idling of both sides.
// ----------------------------------------------------------------------------
module tb_kruskal_union_find_accumulator;
   import ufa_pkg::*;

   // word kinds carried on req_tuser
   localparam logic FUNC_EDGE    = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;

   // cycles with no handshake and no node count write before the run is declared stuck
   localparam int STALL_LIMIT = 20000;
   // cycles to watch for stray results once everything has arrived
   localparam int DRAIN_CYCLES = 64;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic                    func;
      logic [FIELD_NODE_W-1:0] node_a;
      logic [FIELD_NODE_W-1:0] node_b;
      logic [WEIGHT_W-1:0]     weight;
   } edge_word_type;

   typedef struct packed {
      logic              joined;
      logic [COST_W-1:0] cost;
      logic [SETS_W-1:0] sets;
   } mst_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   logic [CSR_W-1:0]      csr_wdata  = '0;

   edge_word_type  edge_q[$];
   mst_result_type mst_results_q[$];
   idle_mode_type  idle_mode    = IDLE_NONE;
   logic           req_taken    = 1'b0;
   int             stall_cycles = 0;
   int             err_count    = 0;

   // own copy of the disjoint-set state
   logic [NODE_W-1:0]  parent_mem [MAX_NODES];
   logic [COST_W-1:0]  tree_cost;
   logic [COUNT_W-1:0] set_total;
   logic [COUNT_W-1:0] node_limit;

   kruskal_union_find_accumulator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      err_count++;
   endtask

   // zero nodes count as one, oversize as the store size
   function automatic logic [COUNT_W-1:0] clip_nodes(input logic [CSR_W-1:0] value);
      if (value == '0) begin
         return COUNT_W'(1);
      end else if (int'(value) > MAX_NODES) begin
         return COUNT_W'(MAX_NODES);
      end
      return COUNT_W'(value);
   endfunction

   // every node its own set, total cleared
   task automatic clear_sets();
      for (int i = 0; i < MAX_NODES; i++) begin
         parent_mem[i] = NODE_W'(i);
      end
      tree_cost = '0;
      set_total = node_limit;
   endtask

   // find the root of x, then point every node on the walked path at it
   task automatic find_root(input logic [NODE_W-1:0] x, output logic [NODE_W-1:0] root);
      logic [NODE_W-1:0] cur;
      logic [NODE_W-1:0] nxt;
      int                steps;
      root  = x;
      steps = 0;
      while (steps < MAX_NODES && parent_mem[root] != root) begin
         root = parent_mem[root];
         steps++;
      end
      cur   = x;
      steps = 0;
      while (cur != root && steps < MAX_NODES) begin
         nxt             = parent_mem[cur];
         parent_mem[cur] = root;
         cur             = nxt;
         steps++;
      end
   endtask

   // one accepted word: update the sets and queue the result it must give
   task automatic apply_word(input logic func, input logic [NODE_W-1:0] a,
                             input logic [NODE_W-1:0] b, input logic [WEIGHT_W-1:0] w);
      logic [NODE_W-1:0] root_a;
      logic [NODE_W-1:0] root_b;
      logic [COST_W:0]   sum;
      mst_result_type    res;
      res.joined = 1'b0;
      if (func == FUNC_RESTART) begin
         clear_sets();
      end else if (COUNT_W'(a) < node_limit && COUNT_W'(b) < node_limit) begin
         find_root(a, root_a);
         find_root(b, root_b);
         if (root_a != root_b) begin
            parent_mem[root_b] = root_a;
            sum = (COST_W+1)'(tree_cost) + (COST_W+1)'(w);
            tree_cost = (sum > (COST_W+1)'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];
            if (set_total > COUNT_W'(1)) set_total = set_total - COUNT_W'(1);
            res.joined = 1'b1;
         end
      end
      res.cost = tree_cost;
      res.sets = SETS_W'(set_total);
      mst_results_q.insert(mst_results_q.size(), res);
   endtask

   function automatic logic sender_ready();
      case (idle_mode)
         IDLE_SEND: begin
            return $urandom_range(99) >= 85;
         end
         IDLE_BOTH: begin
            return $urandom_range(99) >= 12;
         end
         default: begin
            return 1'b1;
         end
      endcase
   endfunction

   function automatic logic receiver_ready();
      case (idle_mode)
         IDLE_RECV: begin
            return $urandom_range(99) >= 85;
         end
         IDLE_BOTH: begin
            return $urandom_range(99) >= 12;
         end
         default: begin
            return 1'b1;
         end
      endcase
   endfunction

   // driver: a word stays on the bus until taken
   always @(negedge clock) begin : driver
      edge_word_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (edge_q.size() != 0 && sender_ready()) begin
            item = edge_q.pop_front();
            req_tdata  <= {3'b000, item.weight, item.node_b, item.node_a};
            req_tuser  <= item.func;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= receiver_ready();
   end

   // monitor: predict on every accepted word, check every result word
   always @(posedge clock) begin : monitor
      mst_result_type got;
      mst_result_type want;
      logic           req_fire;
      logic           rsp_fire;
      req_fire = req_tvalid && req_tready;
      rsp_fire = rsp_tvalid && rsp_tready;
      if (reset) begin
         node_limit = clip_nodes(NODE_COUNT_RESET);
         clear_sets();
         req_taken    <= 1'b0;
         stall_cycles <= 0;
      end else begin
         if (csr_we) begin
            node_limit = clip_nodes(csr_wdata);
            clear_sets();
         end
         if (req_fire) begin
            apply_word(req_tuser, req_tdata[9:0], req_tdata[19:10], req_tdata[60:20]);
         end
         if (rsp_fire) begin
            got.joined = rsp_tdata[0];
            got.cost   = rsp_tdata[63:1];
            got.sets   = rsp_tdata[74:64];
            if (mst_results_q.size() == 0) begin
               report_mismatch($sformatf("result word with none expected: %h", rsp_tdata));
            end else begin
               want = mst_results_q.pop_front();
               if (got.joined !== want.joined)
                  report_mismatch($sformatf("joined %b, expected %b", got.joined, want.joined));
               if (got.cost !== want.cost)
                  report_mismatch($sformatf("total cost %0d, expected %0d", got.cost, want.cost));
               if (got.sets !== want.sets)
                  report_mismatch($sformatf("sets left %0d, expected %0d", got.sets, want.sets));
            end
         end
         req_taken    <= req_fire;
         stall_cycles <= (req_fire || rsp_fire || csr_we) ? 0 : stall_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (stall_cycles >= STALL_LIMIT);
      $display("tb_kruskal_union_find_accumulator NOT OK");
      $finish;
   end

   task automatic push_word(input logic func, input int a, input int b,
                            input logic [WEIGHT_W-1:0] w);
      edge_word_type item;
      item.func   = func;
      item.node_a = FIELD_NODE_W'(a);
      item.node_b = FIELD_NODE_W'(b);
      item.weight = w;
      edge_q.insert(edge_q.size(), item);
   endtask

   // wait until every word is sent, answered and the block takes words again
   task automatic wait_drained();
      do begin
         @(posedge clock);
      end while (!(edge_q.size() == 0 && !req_tvalid && mst_results_q.size() == 0
                   && req_tready));
   endtask

   task automatic write_node_count(input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // mostly in-range edges with rising weights, some restarts and noise
   task automatic run_phase(input logic [CSR_W-1:0] count, input idle_mode_type mode,
                            input int items);
      int                n;
      int                roll;
      logic [WEIGHT_W:0] w_next;
      logic [WEIGHT_W-1:0] w_run;
      wait_drained();
      write_node_count(count);
      idle_mode = mode;
      n     = int'(clip_nodes(count));
      w_run = WEIGHT_W'({$urandom(), $urandom()}) >> $urandom_range(WEIGHT_W-1, 1);
      for (int i = 0; i < items; i++) begin
         roll = $urandom_range(99);
         if (roll < 3) begin
            push_word(FUNC_RESTART, $urandom(), $urandom(), WEIGHT_W'({$urandom(), $urandom()}));
            w_run = '0;
         end else if (roll < 12) begin
            push_word(FUNC_EDGE, $urandom(), $urandom(), WEIGHT_W'({$urandom(), $urandom()}));
         end else begin
            w_next = (WEIGHT_W+1)'(w_run) + (WEIGHT_W+1)'($urandom_range(4096));
            w_run  = w_next[WEIGHT_W] ? '1 : w_next[WEIGHT_W-1:0];
            push_word(FUNC_EDGE, $urandom_range(n-1), $urandom_range(n-1), w_run);
         end
      end
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // full store after reset: extreme nodes and weights, repeats, self loop
      push_word(FUNC_EDGE, 0, 1023, '0);
      push_word(FUNC_EDGE, 1023, 0, '1);
      push_word(FUNC_EDGE, 5, 5, WEIGHT_W'(12));
      push_word(FUNC_EDGE, 1, 2, '1);
      push_word(FUNC_EDGE, 2, 1023, '1);
      push_word(FUNC_EDGE, 0, 2, WEIGHT_W'(7));
      push_word(FUNC_RESTART, 1023, 1023, '1);
      push_word(FUNC_EDGE, 3, 4, WEIGHT_W'(1));
      wait_drained();

      // zero node count acts as a single node; everything else out of range
      write_node_count('0);
      push_word(FUNC_EDGE, 0, 0, WEIGHT_W'(5));
      push_word(FUNC_EDGE, 0, 1, WEIGHT_W'(5));
      push_word(FUNC_EDGE, 1023, 0, WEIGHT_W'(5));
      push_word(FUNC_RESTART, 0, 0, '0);
      wait_drained();

      // oversize node count clips to the store size
      write_node_count('1);
      push_word(FUNC_EDGE, 1023, 1022, WEIGHT_W'(100));
      push_word(FUNC_EDGE, 512, 1023, WEIGHT_W'(200));
      push_word(FUNC_EDGE, 1022, 512, WEIGHT_W'(300));
      wait_drained();

      // three nodes: merge down to one set, then repeated joins and an out of range end
      write_node_count(CSR_W'(3));
      push_word(FUNC_EDGE, 0, 1, WEIGHT_W'(1));
      push_word(FUNC_EDGE, 1, 2, WEIGHT_W'(2));
      push_word(FUNC_EDGE, 2, 0, WEIGHT_W'(3));
      push_word(FUNC_EDGE, 3, 0, WEIGHT_W'(4));
      push_word(FUNC_EDGE, 0, 2, WEIGHT_W'(5));

      // random phases over node counts and idling
      run_phase(CSR_W'(16),   IDLE_NONE, 60);
      run_phase(CSR_W'(8),    IDLE_SEND, 45);
      run_phase(CSR_W'(32),   IDLE_RECV, 55);
      run_phase(CSR_W'(2047), IDLE_BOTH, 50);
      run_phase(CSR_W'(2),    IDLE_NONE, 30);
      run_phase(CSR_W'(100),  IDLE_SEND, 50);
      run_phase(CSR_W'(1100), IDLE_RECV, 45);
      run_phase(CSR_W'(5),    IDLE_BOTH, 40);
      run_phase(CSR_W'(1024), IDLE_NONE, 35);
      run_phase(CSR_W'(64),   IDLE_RECV, 40);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mst_results_q.size() != 0)
         report_mismatch($sformatf("%0d result words never arrived", mst_results_q.size()));
      if (err_count == 0) begin
         $display("tb_kruskal_union_find_accumulator OK");
      end else begin
         $display("tb_kruskal_union_find_accumulator NOT OK");
      end
      $finish;
   end

endmodule
